// ===== rtl/assert_macros.svh =====
// Assertion macros for the MD5 RTL.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, inactive while reset is asserted.
`define MD5_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that stays active through reset.
`define MD5_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/md5_pkg.sv =====
// MD5 package: types, initial vector, round constants and per-round tables.
// Used by md5_round and md5_message_digest_core; no dependencies.
package md5_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned BlkWords = 16;

  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
  } md5_abcd_t;

  localparam logic [WordW-1:0] IV_A = 32'h67452301;
  localparam logic [WordW-1:0] IV_B = 32'hefcdab89;
  localparam logic [WordW-1:0] IV_C = 32'h98badcfe;
  localparam logic [WordW-1:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [WordW-1:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  function automatic logic [WordW-1:0] round_const(input logic [5:0] rnd);
    return ROUND_K[rnd];
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'd0:    s = 5'd7;
      4'd1:    s = 5'd12;
      4'd2:    s = 5'd17;
      4'd3:    s = 5'd22;
      4'd4:    s = 5'd5;
      4'd5:    s = 5'd9;
      4'd6:    s = 5'd14;
      4'd7:    s = 5'd20;
      4'd8:    s = 5'd4;
      4'd9:    s = 5'd11;
      4'd10:   s = 5'd16;
      4'd11:   s = 5'd23;
      4'd12:   s = 5'd6;
      4'd13:   s = 5'd10;
      4'd14:   s = 5'd15;
      4'd15:   s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  // Message word used by a given round.
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] i;
    logic [3:0] g;
    i = rnd[3:0];
    case (rnd[5:4])
      2'd0:    g = i;
      2'd1:    g = 4'(i * 4'd5 + 4'd1);
      2'd2:    g = 4'(i * 4'd3 + 4'd5);
      2'd3:    g = 4'(i * 4'd7);
      default: g = i;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/md5_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module md5_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/md5_round.sv =====
// One MD5 round step: boolean function, four-operand add, rotate, add.
// Depends on md5_pkg.
module md5_round (
  input  md5_pkg::md5_abcd_t       cur,
  input  logic [md5_pkg::WordW-1:0] msg,
  input  logic [5:0]               rnd,
  output md5_pkg::md5_abcd_t       nxt
);

  logic [md5_pkg::WordW-1:0]   f;
  logic [md5_pkg::WordW-1:0]   sum;
  logic [2*md5_pkg::WordW-1:0] rot_wide;
  logic [4:0]                  s;

  always_comb begin
    case (rnd[5:4])
      2'd0:    f = (cur.b & cur.c) | (~cur.b & cur.d);
      2'd1:    f = (cur.b & cur.d) | (cur.c & ~cur.d);
      2'd2:    f = cur.b ^ cur.c ^ cur.d;
      2'd3:    f = cur.c ^ (cur.b | ~cur.d);
      default: f = cur.b ^ cur.c ^ cur.d;
    endcase
    s        = md5_pkg::rot_amount(rnd);
    sum      = cur.a + f + md5_pkg::round_const(rnd) + msg;
    rot_wide = {sum, sum} << s;
    nxt.a    = cur.d;
    nxt.b    = cur.b + rot_wide[2*md5_pkg::WordW-1:md5_pkg::WordW];
    nxt.c    = cur.b;
    nxt.d    = cur.c;
  end

endmodule

// ===== rtl/md5_message_digest_core.sv =====
// MD5 message digest core: top level with sequencer, block store and chaining state.
// Depends on md5_pkg, md5_ram, md5_round and assert_macros.svh.
//
// Usage:
//   Input stream (in_*): one transfer per message byte. in_tdata carries the
//   byte, in_tuser says it is valid, in_tlast closes the message (with or
//   without a byte, so an empty message is a single in_tlast transfer).
//   Output stream (out_*): after in_tlast the four chaining words A, B, C, D
//   follow as four transfers, out_tuser giving the word index and out_tlast
//   marking word D. Digest bytes are each word least significant byte first.
// Timing:
//   Each 64th byte starts a compression (one prefetch, 64 rounds on the shared
//   round unit, one chaining add) before the next byte is taken.
//   Closing a message writes padding one word a cycle (up to 16), runs one
//   or two compressions, then holds the words until the receiver takes them.
//   in_tready is low through each compression and from in_tlast until the
//   last word goes.
// Reset: chaining words return to the initial vector, the byte count to
//   zero, both streams idle. A stalled receiver simply holds the core.
`include "assert_macros.svh"

module md5_message_digest_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_valid
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [1:0]  out_tuser,  // [1:0] word_index
  output logic        out_tlast
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PAD  = 6'b000010,
    S_PRE  = 6'b000100,
    S_RND  = 6'b001000,
    S_ADD  = 6'b010000,
    S_OUT  = 6'b100000
  } md5_state_t;

  localparam int unsigned AddrW = $clog2(md5_pkg::BlkWords);

  md5_state_t                state_r, state_nxt;
  logic [md5_pkg::WordW-1:0] chain_r [4];
  logic [md5_pkg::WordW-1:0] chain_nxt [4];
  md5_pkg::md5_abcd_t        work_r, work_nxt, round_out;
  logic [63:0]               bt_r, bt_nxt;
  logic [31:0]               wbuf_r, wbuf_nxt;
  logic [5:0]                rnd_r, rnd_nxt;
  logic [AddrW-1:0]          pad_w_r, pad_w_nxt;
  logic                      len_blk_r, len_blk_nxt;
  logic                      mark_done_r, mark_done_nxt;
  logic                      fin_r, fin_nxt;
  logic [1:0]                idx_r, idx_nxt;

  logic                      wr_en;
  logic [AddrW-1:0]          wr_addr;
  logic [31:0]               wr_data;
  logic [AddrW-1:0]          rd_addr;
  logic [31:0]               rd_data;
  logic [31:0]               mark_word;
  logic [31:0]               len_word;
  logic [63:0]               bit_len;
  logic [4:0]                lane_sh;
  logic                      in_xfer;

  md5_ram #(
    .WIDTH(md5_pkg::WordW),
    .DEPTH(md5_pkg::BlkWords)
  ) u_blk (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  md5_round u_round (
    .cur(work_r),
    .msg(rd_data),
    .rnd(rnd_r),
    .nxt(round_out)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = chain_r[idx_r];
  assign out_tuser  = idx_r;
  assign out_tlast  = (idx_r == 2'd3);

  assign rd_addr   = md5_pkg::msg_index((state_r == S_RND) ? 6'(rnd_r + 6'd1) : 6'd0);
  assign lane_sh   = {bt_r[1:0], 3'b000};
  assign mark_word = (wbuf_r & ((32'h1 << lane_sh) - 32'h1))
                   | ({24'h0, md5_pkg::PAD_MARK} << lane_sh);
  assign bit_len   = {bt_r[60:0], 3'b000};
  assign len_word  = (pad_w_r == AddrW'(14)) ? bit_len[31:0] :
                     (pad_w_r == AddrW'(15)) ? bit_len[63:32] : 32'h0;

  always_comb begin
    state_nxt     = state_r;
    chain_nxt     = chain_r;
    work_nxt      = work_r;
    bt_nxt        = bt_r;
    wbuf_nxt      = wbuf_r;
    rnd_nxt       = rnd_r;
    pad_w_nxt     = pad_w_r;
    len_blk_nxt   = len_blk_r;
    mark_done_nxt = mark_done_r;
    fin_nxt       = fin_r;
    idx_nxt       = idx_r;
    wr_en         = 1'b0;
    wr_addr       = bt_r[5:2];
    wr_data       = {in_tdata, wbuf_r[23:0]};

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_tuser) begin
            wbuf_nxt[8*bt_r[1:0] +: 8] = in_tdata;
            wr_en  = (bt_r[1:0] == 2'd3);
            bt_nxt = bt_r + 64'd1;
          end
          if (in_tlast) begin
            fin_nxt       = 1'b1;
            pad_w_nxt     = bt_nxt[5:2];
            len_blk_nxt   = (bt_nxt[5:2] < AddrW'(14));
            mark_done_nxt = 1'b0;
          end
          if (in_tuser && bt_r[5:0] == 6'd63) begin
            state_nxt = S_PRE;
          end else if (in_tlast) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        wr_en         = 1'b1;
        wr_addr       = pad_w_r;
        wr_data       = mark_done_r ? (len_blk_r ? len_word : 32'h0) : mark_word;
        mark_done_nxt = 1'b1;
        if (pad_w_r == AddrW'(md5_pkg::BlkWords - 1)) begin
          state_nxt = S_PRE;
        end else begin
          pad_w_nxt = pad_w_r + AddrW'(1);
        end
      end
      S_PRE: begin
        work_nxt  = '{a: chain_r[0], b: chain_r[1], c: chain_r[2], d: chain_r[3]};
        rnd_nxt   = 6'd0;
        state_nxt = S_RND;
      end
      S_RND: begin
        work_nxt = round_out;
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        chain_nxt[0] = chain_r[0] + work_r.a;
        chain_nxt[1] = chain_r[1] + work_r.b;
        chain_nxt[2] = chain_r[2] + work_r.c;
        chain_nxt[3] = chain_r[3] + work_r.d;
        if (!fin_r) begin
          state_nxt = S_IDLE;
        end else if (mark_done_r && len_blk_r) begin
          idx_nxt   = 2'd0;
          state_nxt = S_OUT;
        end else begin
          if (mark_done_r) begin
            len_blk_nxt = 1'b1;
            pad_w_nxt   = '0;
          end
          state_nxt = S_PAD;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          if (idx_r == 2'd3) begin
            chain_nxt[0] = md5_pkg::IV_A;
            chain_nxt[1] = md5_pkg::IV_B;
            chain_nxt[2] = md5_pkg::IV_C;
            chain_nxt[3] = md5_pkg::IV_D;
            bt_nxt       = 64'd0;
            fin_nxt      = 1'b0;
            state_nxt    = S_IDLE;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      chain_r[0] <= md5_pkg::IV_A;
      chain_r[1] <= md5_pkg::IV_B;
      chain_r[2] <= md5_pkg::IV_C;
      chain_r[3] <= md5_pkg::IV_D;
      bt_r       <= 64'd0;
      fin_r      <= 1'b0;
      idx_r      <= 2'd0;
      rnd_r      <= 6'd0;
    end else begin
      state_r <= state_nxt;
      chain_r <= chain_nxt;
      bt_r    <= bt_nxt;
      fin_r   <= fin_nxt;
      idx_r   <= idx_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r      <= work_nxt;
    wbuf_r      <= wbuf_nxt;
    pad_w_r     <= pad_w_nxt;
    len_blk_r   <= len_blk_nxt;
    mark_done_r <= mark_done_nxt;
  end

  `MD5_ASSERT(a_one_side, !(in_tready && out_tvalid), "input and output both active")
  `MD5_ASSERT(a_last_to_idle, (out_tvalid && out_tready && out_tlast) |=> in_tready,
              "core not idle after last digest word")
  `MD5_ASSERT(a_rounds_end, (state_r == S_RND && rnd_r == 6'd63) |=> (state_r == S_ADD),
              "compression did not end after 64 rounds")
  `MD5_ASSERT(a_out_needs_fin, out_tvalid |-> fin_r, "digest shown without a closed message")

endmodule

// ===== dv/md5_message_digest_core_test.sv =====
// Self-checking testbench for md5_message_digest_core: byte stream in, digest words out.
// Carries its own MD5 predictor; needs md5_message_digest_core and its RTL dependencies.
`timescale 1ns / 100ps

module md5_message_digest_core_test;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       fin;
  } md5_item_t;

  typedef struct packed {
    logic [7:0]   data;
    logic         valid;
    logic         fin;
    logic         typed;
    logic [127:0] words;  // {A, B, C, D}
  } stim_row_t;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int          LEN_POS = 56;
  localparam int          HOLD_CYCLES = 400;
  localparam int          IDLE_PCT = 16;
  localparam int          ROT_TAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                           4, 11, 16, 23, 6, 10, 15, 21};
  localparam int          EDGE_LEN [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

  localparam logic [127:0] DIG_EMPTY =
    {32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec};
  localparam logic [127:0] DIG_A =
    {32'hb975c10c, 32'ha8b6f1c0, 32'he299c331, 32'h61267769};

  localparam int N_DIR = 14;
  localparam stim_row_t DIR_TAB [N_DIR] = '{
    '{8'ha5, 1'b0, 1'b0, 1'b0, '0},         // ignored after reset
    '{8'h00, 1'b0, 1'b1, 1'b1, DIG_EMPTY},  // empty message
    '{8'h61, 1'b1, 1'b1, 1'b1, DIG_A},      // byte and end together
    '{8'h00, 1'b1, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, 1'b0, '0},         // ignored mid-message
    '{8'hff, 1'b1, 1'b0, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, 1'b0, '0},
    '{8'h5a, 1'b0, 1'b1, 1'b0, '0},         // end, data byte not used
    '{8'h01, 1'b1, 1'b0, 1'b0, '0},
    '{8'h7f, 1'b1, 1'b0, 1'b0, '0},
    '{8'hfe, 1'b1, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'haa, 1'b1, 1'b0, 1'b0, '0},
    '{8'h55, 1'b0, 1'b1, 1'b0, '0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tuser;   // [0] byte_valid
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] digest_word
  logic [1:0]  out_tuser;  // [1:0] word_index
  logic        out_tlast;

  md5_message_digest_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // predictor state
  logic [31:0] md5_k [64];
  logic [31:0] md5_chain [4];
  logic [7:0]  md5_blk [64];
  logic [63:0] md5_len;
  int          md5_fill;

  digest_word_t digest_q [$];
  int err_cnt;
  int words_seen;
  int items_sent;
  int digests_sent;
  int longest_msg;
  bit quiet;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Timeout: %0d digest words still outstanding", digest_q.size());
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch %s: got %h, expected %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  function automatic void md5_init();
    real s;
    for (int i = 0; i < 64; i++) begin
      s = $sin(i + 1);
      if (s < 0.0) s = -s;
      md5_k[i] = 32'(longint'($floor(s * 4294967296.0)));
    end
    md5_chain = '{INIT_A, INIT_B, INIT_C, INIT_D};
    md5_len = '0;
    md5_fill = 0;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic void md5_compress();
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t;
    int g;
    int st;
    for (int i = 0; i < 16; i++)
      m[i] = {md5_blk[4*i+3], md5_blk[4*i+2], md5_blk[4*i+1], md5_blk[4*i]};
    a = md5_chain[0];
    b = md5_chain[1];
    c = md5_chain[2];
    d = md5_chain[3];
    for (int i = 0; i < 64; i++) begin
      st = i / 16;
      case (st)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = 5 * i + 1; end
        2: begin f = b ^ c ^ d;          g = 3 * i + 5; end
        default: begin f = c ^ (b | ~d); g = 7 * i; end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rotl(a + f + md5_k[i] + m[g % 16], ROT_TAB[st * 4 + i % 4]);
      a = t;
    end
    md5_chain[0] += a;
    md5_chain[1] += b;
    md5_chain[2] += c;
    md5_chain[3] += d;
  endfunction

  function automatic void md5_put(input logic [7:0] v);
    md5_blk[md5_fill] = v;
    md5_fill++;
    if (md5_fill == 64) begin
      md5_compress();
      md5_fill = 0;
    end
  endfunction

  // Advances the predictor by one accepted transfer; done is set when a digest falls out.
  function automatic void md5_step(input md5_item_t it, output bit done,
                                   output logic [127:0] words);
    logic [63:0] bits;
    done = 1'b0;
    words = '0;
    if (it.valid) begin
      md5_put(it.data);
      md5_len++;
    end
    if (it.fin) begin
      bits = md5_len << 3;
      md5_put(PAD_BYTE);
      while (md5_fill != LEN_POS) md5_put(8'h00);
      for (int k = 0; k < 8; k++) md5_put(bits[8*k +: 8]);
      words = {md5_chain[0], md5_chain[1], md5_chain[2], md5_chain[3]};
      done = 1'b1;
      md5_chain = '{INIT_A, INIT_B, INIT_C, INIT_D};
      md5_len = '0;
    end
  endfunction

  task automatic drive_item(input md5_item_t it, input bit typed,
                            input logic [127:0] typed_words);
    bit done;
    logic [127:0] words;
    digest_word_t dw;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it.data;
    in_tuser  <= it.valid;
    in_tlast  <= it.fin;
    do @(posedge clk); while (!in_tready);
    if (it.valid || it.fin) items_sent++;
    md5_step(it, done, words);
    if (done) begin
      if (typed) words = typed_words;
      for (int k = 0; k < 4; k++) begin
        dw.word = words[127 - 32*k -: 32];
        dw.idx  = 2'(k);
        dw.last = (k == 3);
        digest_q = {digest_q, dw};
      end
      digests_sent++;
    end
  endtask

  task automatic send_message(input int len);
    md5_item_t it;
    for (int j = 0; j < len; j++) begin
      if ($urandom_range(99) < 5) begin
        it = '{data: 8'($urandom), valid: 1'b0, fin: 1'b0};
        drive_item(it, 1'b0, '0);
      end
      it = '{data: 8'($urandom), valid: 1'b1, fin: 1'b0};
      if (j == len - 1 && $urandom_range(1)) it.fin = 1'b1;
      drive_item(it, 1'b0, '0);
    end
    if (len == 0 || !it.fin) begin
      it = '{data: 8'($urandom), valid: 1'b0, fin: 1'b1};
      drive_item(it, 1'b0, '0);
    end
    if (len > longest_msg) longest_msg = len;
  endtask

  // receiver
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    digest_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      words_seen++;
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected digest word", out_tdata, 32'h0);
      end else begin
        want = digest_q.pop_front();
        if (out_tdata !== want.word) report_mismatch("digest_word", out_tdata, want.word);
        if (out_tuser !== want.idx)
          report_mismatch("word_index", 32'(out_tuser), 32'(want.idx));
        if (out_tlast !== want.last)
          report_mismatch("last_word", 32'(out_tlast), 32'(want.last));
      end
    end
  end

  initial begin
    md5_item_t it;
    int len;
    int msg_no;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    err_cnt = 0;
    words_seen = 0;
    items_sent = 0;
    digests_sent = 0;
    longest_msg = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    md5_init();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIR; r++) begin
      it = '{data: DIR_TAB[r].data, valid: DIR_TAB[r].valid, fin: DIR_TAB[r].fin};
      drive_item(it, DIR_TAB[r].typed, DIR_TAB[r].words);
    end
    in_tvalid <= 1'b0;
    wait (digest_q.size() == 0);
    @(posedge clk);

    // receiver holds off while messages keep coming
    hold_req = 1'b1;
    msg_no = 0;
    while (items_sent < 330 || msg_no < 8) begin
      quiet = (msg_no >= 2 && msg_no < 6);
      if (msg_no == 6) begin
        in_tvalid <= 1'b0;
        wait (digest_q.size() == 0);
        @(posedge clk);
      end
      case ($urandom_range(9))
        0, 1: len = EDGE_LEN[$urandom_range(8)];
        2:    len = $urandom_range(130, 65);
        default: len = $urandom_range(12);
      endcase
      send_message(len);
      msg_no++;
    end
    quiet = 1'b0;
    in_tvalid <= 1'b0;

    wait (digest_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d byte/end transfers in %0d messages (longest %0d bytes),",
             items_sent, digests_sent, longest_msg);
    $display("checked %0d digest words under random stalls and a long receiver hold-off.",
             words_seen);
    if (err_cnt == 0 && digest_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/md5_pkg.sv
rtl/md5_ram.sv
rtl/md5_round.sv
rtl/md5_message_digest_core.sv
dv/md5_message_digest_core_test.sv
